// File: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables it.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A stalled valid beat stays valid and keeps its payload.
`define ASSERT_HOLD(label, clk, rst_n, vld, stl, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && (stl)) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

// File: src/dlle_pkg.sv
// Types and codes of the doubly linked list engine.
package dlle_pkg;

    localparam logic [1:0] OP_INS_HEAD = 2'd0;
    localparam logic [1:0] OP_INS_TAIL = 2'd1;
    localparam logic [1:0] OP_DELETE   = 2'd2;

    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_NO_MATCH = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;

    localparam int COUNT_W = 7;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] element_count;
    } t_rsp;

    typedef struct packed {
        logic alloc;
        logic free;
    } t_pool_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_LINK,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

// File: src/dlle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dlle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/dlle_free_pool.sv
// Node allocator: a stack of returned slots backed by a high-water counter.
module dlle_free_pool #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dlle_pkg::t_pool_cmd         i_cmd,
    input  logic [$clog2(CAPACITY)-1:0] i_free_slot,
    output logic [$clog2(CAPACITY)-1:0] o_slot
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    logic [LW-1:0] r_sp, n_sp;
    logic [LW-1:0] r_hwm, n_hwm;
    logic          r_from_stack, n_from_stack;
    logic [AW-1:0] r_new_slot, n_new_slot;
    logic          stack_rd_en;
    logic [AW-1:0] stack_rd_data;

    // Slots never handed out come from the high-water mark; freed slots
    // go on the stack and are reused first. Callers never ask for a slot
    // when all of them are in use.
    always_comb begin
        n_sp         = r_sp;
        n_hwm        = r_hwm;
        n_from_stack = r_from_stack;
        n_new_slot   = r_new_slot;
        stack_rd_en  = 1'b0;
        if (i_cmd.alloc) begin
            if (r_sp != '0) begin
                stack_rd_en  = 1'b1;
                n_sp         = r_sp - 1'b1;
                n_from_stack = 1'b1;
            end else begin
                n_new_slot   = r_hwm[AW-1:0];
                n_hwm        = r_hwm + 1'b1;
                n_from_stack = 1'b0;
            end
        end else if (i_cmd.free) begin
            n_sp = r_sp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp  <= '0;
            r_hwm <= '0;
        end else begin
            r_sp  <= n_sp;
            r_hwm <= n_hwm;
        end
        r_from_stack <= n_from_stack;
        r_new_slot   <= n_new_slot;
    end

    dlle_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.free),
        .i_wr_addr (r_sp[AW-1:0]),
        .i_wr_data (i_free_slot),
        .i_rd_en   (stack_rd_en),
        .i_rd_addr (AW'(r_sp - 1'b1)),
        .o_rd_data (stack_rd_data)
    );

    assign o_slot = r_from_stack ? stack_rd_data : r_new_slot;

endmodule

// File: src/doubly_linked_list_engine_core.sv
// Doubly linked list engine: a bounded list of signed 32-bit values kept in
// node RAMs with previous and next links. Each request beat yields exactly one
// response beat with a status and the element count after the request, and the
// input stalls while a request is in progress. An insert at head or tail goes
// through ST_ALLOC, ST_LINK (skipped for an empty list) and ST_DONE; an insert
// into a full list or an unused op goes straight to ST_DONE. Delete walks up
// to CAPACITY nodes from the head, reading one node per cycle from the node
// RAMs and feeding the next link straight back as the next read address; a
// single comparator checks each value. A response beat is held until taken.
module doubly_linked_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dlle_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dlle_pkg::t_rsp o_out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NO_NODE = LW'(CAPACITY);

    dlle_pkg::t_state r_state, n_state;
    logic [1:0]       r_op, n_op;
    logic [31:0]      r_value, n_value;
    logic [1:0]       r_status, n_status;
    logic [LW-1:0]    r_head, n_head;
    logic [LW-1:0]    r_tail, n_tail;
    logic [LW-1:0]    r_count, n_count;
    logic [LW-1:0]    r_cur, n_cur;
    logic [LW-1:0]    r_steps, n_steps;
    logic [LW-1:0]    r_nbr, n_nbr;
    logic [AW-1:0]    r_slot, n_slot;
    logic             r_out_valid, n_out_valid;
    dlle_pkg::t_rsp   r_out_data, n_out_data;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          val_we, next_we, prev_we;
    logic [AW-1:0] val_waddr, next_waddr, prev_waddr;
    logic [LW-1:0] next_wdata, prev_wdata;
    logic [31:0]   val_rd;
    logic [LW-1:0] next_rd, prev_rd;
    logic [LW-1:0] steps_inc;
    logic          is_empty;

    dlle_pkg::t_pool_cmd pool_cmd;
    logic [AW-1:0]       pool_slot;

    assign steps_inc = r_steps + 1'b1;
    assign is_empty  = (r_head >= NO_NODE) || (r_tail >= NO_NODE);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_value     = r_value;
        n_status    = r_status;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_nbr       = r_nbr;
        n_slot      = r_slot;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = 1'b1;
        rd_en       = 1'b0;
        rd_addr     = r_cur[AW-1:0];
        val_we      = 1'b0;
        next_we     = 1'b0;
        prev_we     = 1'b0;
        val_waddr   = pool_slot;
        next_waddr  = pool_slot;
        prev_waddr  = pool_slot;
        next_wdata  = NO_NODE;
        prev_wdata  = NO_NODE;
        pool_cmd    = '0;

        case (r_state)
            dlle_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_op    = i_in_data.op;
                    n_value = i_in_data.value;
                    case (i_in_data.op)
                        dlle_pkg::OP_INS_HEAD, dlle_pkg::OP_INS_TAIL: begin
                            if (r_count == NO_NODE) begin
                                n_status = dlle_pkg::STAT_FULL;
                                n_state  = dlle_pkg::ST_DONE;
                            end else begin
                                pool_cmd.alloc = 1'b1;
                                n_state        = dlle_pkg::ST_ALLOC;
                            end
                        end
                        dlle_pkg::OP_DELETE: begin
                            if (r_head >= NO_NODE || r_count == '0) begin
                                n_status = dlle_pkg::STAT_NO_MATCH;
                                n_state  = dlle_pkg::ST_DONE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head[AW-1:0];
                                n_cur   = r_head;
                                n_steps = '0;
                                n_state = dlle_pkg::ST_WALK;
                            end
                        end
                        default: begin
                            n_status = dlle_pkg::STAT_DONE;
                            n_state  = dlle_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            dlle_pkg::ST_ALLOC: begin
                val_we   = 1'b1;
                next_we  = 1'b1;
                prev_we  = 1'b1;
                n_slot   = pool_slot;
                n_count  = r_count + 1'b1;
                n_status = dlle_pkg::STAT_DONE;
                if (is_empty) begin
                    n_head  = LW'(pool_slot);
                    n_tail  = LW'(pool_slot);
                    n_state = dlle_pkg::ST_DONE;
                end else if (r_op == dlle_pkg::OP_INS_HEAD) begin
                    next_wdata = r_head;
                    n_nbr      = r_head;
                    n_head     = LW'(pool_slot);
                    n_state    = dlle_pkg::ST_LINK;
                end else begin
                    prev_wdata = r_tail;
                    n_nbr      = r_tail;
                    n_tail     = LW'(pool_slot);
                    n_state    = dlle_pkg::ST_LINK;
                end
            end
            dlle_pkg::ST_LINK: begin
                // Point the old end node's link at the new one.
                if (r_op == dlle_pkg::OP_INS_HEAD) begin
                    prev_we    = 1'b1;
                    prev_waddr = r_nbr[AW-1:0];
                    prev_wdata = LW'(r_slot);
                end else begin
                    next_we    = 1'b1;
                    next_waddr = r_nbr[AW-1:0];
                    next_wdata = LW'(r_slot);
                end
                n_state = dlle_pkg::ST_DONE;
            end
            dlle_pkg::ST_WALK: begin
                if (val_rd == r_value) begin
                    if (prev_rd < NO_NODE) begin
                        next_we    = 1'b1;
                        next_waddr = prev_rd[AW-1:0];
                        next_wdata = next_rd;
                    end else begin
                        n_head = next_rd;
                    end
                    if (next_rd < NO_NODE) begin
                        prev_we    = 1'b1;
                        prev_waddr = next_rd[AW-1:0];
                        prev_wdata = prev_rd;
                    end else begin
                        n_tail = prev_rd;
                    end
                    pool_cmd.free = 1'b1;
                    n_count       = r_count - 1'b1;
                    if (r_count == LW'(1)) begin
                        n_head = NO_NODE;
                        n_tail = NO_NODE;
                    end
                    n_status = dlle_pkg::STAT_DONE;
                    n_state  = dlle_pkg::ST_DONE;
                end else if (next_rd < NO_NODE && steps_inc < r_count) begin
                    // The next link goes straight back out as the read address.
                    rd_en   = 1'b1;
                    rd_addr = next_rd[AW-1:0];
                    n_cur   = next_rd;
                    n_steps = steps_inc;
                end else begin
                    n_status = dlle_pkg::STAT_NO_MATCH;
                    n_state  = dlle_pkg::ST_DONE;
                end
            end
            dlle_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_data.status        = r_status;
                    n_out_data.element_count = dlle_pkg::COUNT_W'(r_count);
                    n_state                  = dlle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dlle_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlle_pkg::ST_IDLE;
            r_head      <= NO_NODE;
            r_tail      <= NO_NODE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_value    <= n_value;
        r_status   <= n_status;
        r_cur      <= n_cur;
        r_steps    <= n_steps;
        r_nbr      <= n_nbr;
        r_slot     <= n_slot;
        r_out_data <= n_out_data;
    end

    dlle_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (val_we),
        .i_wr_addr (val_waddr),
        .i_wr_data (r_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (val_rd)
    );

    dlle_ram #(
        .WIDTH (LW),
        .DEPTH (CAPACITY)
    ) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_we),
        .i_wr_addr (next_waddr),
        .i_wr_data (next_wdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (next_rd)
    );

    dlle_ram #(
        .WIDTH (LW),
        .DEPTH (CAPACITY)
    ) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prev_we),
        .i_wr_addr (prev_waddr),
        .i_wr_data (prev_wdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (prev_rd)
    );

    dlle_free_pool #(
        .CAPACITY (CAPACITY)
    ) u_free_pool (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (pool_cmd),
        .i_free_slot (r_cur[AW-1:0]),
        .o_slot      (pool_slot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: src/dlle_checker.sv
// Port-level checks of the doubly linked list engine, bound to its top level.
`include "assert_macros.svh"

module dlle_checker #(
    parameter int CAPACITY = 64
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input dlle_pkg::t_req i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input dlle_pkg::t_rsp o_out_data
);

    localparam logic [dlle_pkg::COUNT_W-1:0] FULL_COUNT = dlle_pkg::COUNT_W'(CAPACITY);

    // An accepted request beat is always followed by a stalled input.
    `ASSERT_CLKD(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input not stalled after a request beat")

    // A refused insert reports a full list.
    `ASSERT_CLKD(a_full_count, i_clk, i_rst_n, (o_out_valid && (o_out_data.status == dlle_pkg::STAT_FULL)) |-> (o_out_data.element_count == FULL_COUNT), "full status with a count below capacity")

    // A new response only appears while a request is in progress.
    `ASSERT_CLKD(a_rsp_from_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "response beat without a request in progress")

    `ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_out_valid, i_out_stall, o_out_data, "stalled response beat changed")

endmodule

bind doubly_linked_list_engine_core dlle_checker #(
    .CAPACITY (CAPACITY)
) u_dlle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
